// File: hw/rtl/assert_macros.svh
// Assertion helpers: same-cycle and next-cycle implication, reset masked
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/spb_pkg.sv
package spb_pkg;

  localparam int MAX_MODULES = 8;

  localparam int SLOT_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int CNT_W  = $clog2(MAX_MODULES + 1);
  localparam int VOLT_W = 16;
  localparam int SUM_W  = VOLT_W + SLOT_W;
  localparam int DIVC_W = $clog2(SUM_W);
  localparam int ERR_W  = VOLT_W + 1;
  localparam int PROD_W = 2 * ERR_W;
  localparam int INTEG_W = 48;
  localparam int ACC_W  = 64;
  localparam int DSUM_W = 42;
  localparam int KPT_W  = PROD_W - 8;

  localparam int IDX_W   = 3;
  localparam int DUTY_W  = 16;
  localparam int GAIN_W  = 16;

  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [1:0] REG_DT_STEP  = 2'd0;
  localparam logic [1:0] REG_DUTY_MIN = 2'd1;
  localparam logic [1:0] REG_DUTY_MAX = 2'd2;

  localparam logic [15:0] DT_STEP_RST  = 16'd655;
  localparam logic [15:0] DUTY_MIN_RST = 16'd3277;
  localparam logic [15:0] DUTY_MAX_RST = 16'd62259;
  localparam logic [DUTY_W-1:0] DUTY_RST = 16'd32768;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_PRESET = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  module_index;
    logic [VOLT_W-1:0] voltage;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [DUTY_W-1:0] preset_duty;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  module_slot;
    logic [DUTY_W-1:0] duty;
    logic              last_result;
  } out_item_t;

endpackage

// File: hw/rtl/spb_if.sv
interface spb_in_if;
  logic               valid;
  logic               ready;
  spb_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spb_out_if;
  logic               valid;
  logic               ready;
  spb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/series_module_pi_balancer.sv
// Steps: a sample or preset request is taken in S_IDLE; a round-ending sample then
// runs the bit-serial averaging divider (S_DIV) and then, per module, the steps S_ERR,
// S_MDT, S_MKP, S_MLO, S_MMID, S_MHI, S_MACC and S_DUTY. One shared 17x17 signed
// multiplier serves every product; no new request is taken until the round is through,
// and output back-pressure can hold S_DUTY. Reset (rst_n, synchronous, active low):
// registers back to defaults, slot count and sum cleared, every duty set to half, every integral cleared.
`include "assert_macros.svh"

module series_module_pi_balancer (
  input  logic                         clk,
  input  logic                         rst_n,
  spb_in_if.sink                       in_ch,
  spb_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spb_pkg::CFG_AW-1:0]   paddr,
  input  logic [spb_pkg::CFG_DW-1:0]   pwdata,
  output logic [spb_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ERR, S_MDT, S_MKP, S_MLO, S_MMID, S_MHI, S_MACC, S_DUTY
  } state_t;

  state_t state_r;

  logic [15:0] dt_step_r, duty_min_r, duty_max_r;

  logic [spb_pkg::CNT_W-1:0]  slot_cnt_r;
  logic [spb_pkg::SUM_W-1:0]  sum_r;
  logic [spb_pkg::SLOT_W-1:0] idx_r;

  logic [spb_pkg::VOLT_W-1:0] volt_mem_r [spb_pkg::MAX_MODULES];
  logic [spb_pkg::GAIN_W-1:0] kp_mem_r   [spb_pkg::MAX_MODULES];
  logic [spb_pkg::GAIN_W-1:0] ki_mem_r   [spb_pkg::MAX_MODULES];
  logic [spb_pkg::DUTY_W-1:0] duty_mem_r [spb_pkg::MAX_MODULES];
  logic signed [spb_pkg::INTEG_W-1:0] integ_mem_r [spb_pkg::MAX_MODULES];

  logic [spb_pkg::DIVC_W-1:0] div_cnt_r;
  logic [spb_pkg::CNT_W-1:0]  rem_r;
  logic [spb_pkg::SUM_W-1:0]  quo_r;

  logic signed [spb_pkg::ERR_W-1:0]   err_r;
  logic signed [spb_pkg::PROD_W-1:0]  prod_r;
  logic signed [spb_pkg::INTEG_W-1:0] integ_r;
  logic signed [spb_pkg::KPT_W-1:0]   kpterm_r;
  logic signed [spb_pkg::ACC_W-1:0]   acc_r;

  logic                out_valid_r;
  spb_pkg::out_item_t  out_data_r;

  logic in_acc, cfg_wr;
  logic [spb_pkg::CNT_W-1:0] cnt_nxt;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    unique case (paddr[3:2])
      spb_pkg::REG_DT_STEP:  prdata = {16'd0, dt_step_r};
      spb_pkg::REG_DUTY_MIN: prdata = {16'd0, duty_min_r};
      spb_pkg::REG_DUTY_MAX: prdata = {16'd0, duty_max_r};
      default:               prdata = '0;
    endcase
  end

  // divider step
  logic [spb_pkg::CNT_W:0]   div_trial;
  logic                      div_ge;
  logic [spb_pkg::CNT_W:0]   div_diff;
  logic [spb_pkg::CNT_W-1:0] rem_nxt;

  assign div_trial = {rem_r, quo_r[spb_pkg::SUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, slot_cnt_r};
  assign div_diff  = div_trial - {1'b0, slot_cnt_r};
  assign rem_nxt   = div_ge ? div_diff[spb_pkg::CNT_W-1:0]
                            : div_trial[spb_pkg::CNT_W-1:0];

  // shared multiplier
  logic signed [spb_pkg::ERR_W-1:0]  mul_a, mul_b;
  logic signed [spb_pkg::PROD_W-1:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_MDT: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, dt_step_r});
      end
      S_MKP: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, kp_mem_r[idx_r]});
      end
      S_MLO: begin
        mul_a = $signed({1'b0, ki_mem_r[idx_r]});
        mul_b = $signed({1'b0, integ_r[15:0]});
      end
      S_MMID: begin
        mul_a = $signed({1'b0, ki_mem_r[idx_r]});
        mul_b = $signed({1'b0, integ_r[31:16]});
      end
      S_MHI: begin
        mul_a = $signed({1'b0, ki_mem_r[idx_r]});
        mul_b = $signed({integ_r[47], integ_r[47:32]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // integral update with saturation
  logic signed [spb_pkg::INTEG_W:0]   integ_sum;
  logic signed [spb_pkg::INTEG_W-1:0] integ_sat;

  assign integ_sum = (spb_pkg::INTEG_W + 1)'(integ_mem_r[idx_r])
                   + (spb_pkg::INTEG_W + 1)'(prod_r);

  always_comb begin
    priority if (integ_sum[spb_pkg::INTEG_W] == integ_sum[spb_pkg::INTEG_W-1]) begin
      integ_sat = integ_sum[spb_pkg::INTEG_W-1:0];
    end else if (integ_sum[spb_pkg::INTEG_W]) begin
      integ_sat = {1'b1, {(spb_pkg::INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(spb_pkg::INTEG_W-1){1'b1}}};
    end
  end

  // duty update and clamp
  logic signed [spb_pkg::DSUM_W-1:0] dsum;
  logic signed [spb_pkg::ACC_W-1:0]  ki_term;
  logic [spb_pkg::DUTY_W-1:0]        duty_new;
  logic                              out_free, round_end;

  assign ki_term = acc_r >>> 24;
  assign dsum = $signed({{(spb_pkg::DSUM_W-spb_pkg::DUTY_W){1'b0}}, duty_mem_r[idx_r]})
              + spb_pkg::DSUM_W'(kpterm_r)
              + spb_pkg::DSUM_W'(ki_term);

  always_comb begin
    priority if (dsum < $signed({{(spb_pkg::DSUM_W-16){1'b0}}, duty_min_r})) begin
      duty_new = duty_min_r;
    end else begin
      duty_new = dsum[spb_pkg::DUTY_W-1:0];
    end
    if (dsum > $signed({{(spb_pkg::DSUM_W-16){1'b0}}, duty_max_r}) ||
        duty_new > duty_max_r) begin
      duty_new = duty_max_r;
    end
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign round_end = (spb_pkg::CNT_W'(idx_r) + spb_pkg::CNT_W'(1)) == slot_cnt_r;
  assign cnt_nxt   = (slot_cnt_r < spb_pkg::CNT_W'(spb_pkg::MAX_MODULES))
                   ? slot_cnt_r + spb_pkg::CNT_W'(1) : slot_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dt_step_r   <= spb_pkg::DT_STEP_RST;
      duty_min_r  <= spb_pkg::DUTY_MIN_RST;
      duty_max_r  <= spb_pkg::DUTY_MAX_RST;
      slot_cnt_r  <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < spb_pkg::MAX_MODULES; i++) begin
        duty_mem_r[i]  <= spb_pkg::DUTY_RST;
        integ_mem_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          spb_pkg::REG_DT_STEP:  dt_step_r  <= pwdata[15:0];
          spb_pkg::REG_DUTY_MIN: duty_min_r <= pwdata[15:0];
          spb_pkg::REG_DUTY_MAX: duty_max_r <= pwdata[15:0];
          default: ;
        endcase
      end

      // raise on a new result, drop the result once taken
      if (state_r == S_DUTY && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.data.mode == spb_pkg::MODE_PRESET) begin
              if (32'(in_ch.data.module_index) < spb_pkg::MAX_MODULES) begin
                duty_mem_r[spb_pkg::SLOT_W'(in_ch.data.module_index)] <=
                  in_ch.data.preset_duty;
                integ_mem_r[spb_pkg::SLOT_W'(in_ch.data.module_index)] <= '0;
              end
            end else begin
              if (slot_cnt_r < spb_pkg::CNT_W'(spb_pkg::MAX_MODULES)) begin
                volt_mem_r[spb_pkg::SLOT_W'(slot_cnt_r)] <= in_ch.data.voltage;
                kp_mem_r[spb_pkg::SLOT_W'(slot_cnt_r)]   <= in_ch.data.kp_gain;
                ki_mem_r[spb_pkg::SLOT_W'(slot_cnt_r)]   <= in_ch.data.ki_gain;
                sum_r <= sum_r + spb_pkg::SUM_W'(in_ch.data.voltage);
                quo_r <= sum_r + spb_pkg::SUM_W'(in_ch.data.voltage);
              end else begin
                quo_r <= sum_r;
              end
              slot_cnt_r <= cnt_nxt;
              rem_r      <= '0;
              div_cnt_r  <= '0;
              if (in_ch.data.last_sample) begin
                state_r <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= {quo_r[spb_pkg::SUM_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + spb_pkg::DIVC_W'(1);
          if (div_cnt_r == spb_pkg::DIVC_W'(spb_pkg::SUM_W - 1)) begin
            idx_r   <= '0;
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          err_r   <= $signed({1'b0, volt_mem_r[idx_r]})
                   - $signed({1'b0, quo_r[spb_pkg::VOLT_W-1:0]});
          state_r <= S_MDT;
        end
        S_MDT: begin
          prod_r  <= mul_p;
          state_r <= S_MKP;
        end
        S_MKP: begin
          integ_r <= integ_sat;
          prod_r  <= mul_p;
          state_r <= S_MLO;
        end
        S_MLO: begin
          kpterm_r <= spb_pkg::KPT_W'(prod_r >>> 8);
          prod_r   <= mul_p;
          state_r  <= S_MMID;
        end
        S_MMID: begin
          acc_r   <= spb_pkg::ACC_W'(prod_r);
          prod_r  <= mul_p;
          state_r <= S_MHI;
        end
        S_MHI: begin
          acc_r   <= acc_r + (spb_pkg::ACC_W'(prod_r) <<< 16);
          prod_r  <= mul_p;
          state_r <= S_MACC;
        end
        S_MACC: begin
          acc_r   <= acc_r + (spb_pkg::ACC_W'(prod_r) <<< 32);
          state_r <= S_DUTY;
        end
        S_DUTY: begin
          // hold until the output register is free
          if (out_free) begin
            duty_mem_r[idx_r]  <= duty_new;
            integ_mem_r[idx_r] <= integ_r;
            out_data_r.module_slot   <= spb_pkg::IDX_W'(idx_r);
            out_data_r.duty          <= duty_new;
            out_data_r.last_result   <= round_end;
            if (round_end) begin
              slot_cnt_r <= '0;
              sum_r      <= '0;
              state_r    <= S_IDLE;
            end else begin
              idx_r   <= idx_r + spb_pkg::SLOT_W'(1);
              state_r <= S_ERR;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SPB_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, slot_cnt_r <= spb_pkg::CNT_W'(spb_pkg::MAX_MODULES), "slot count beyond module count")
  `SPB_ASSERT_NXT(a_round_start, clk, rst_n, in_acc && (in_ch.data.mode == spb_pkg::MODE_SAMPLE) && in_ch.data.last_sample, state_r == S_DIV, "round end did not start averaging")
  `SPB_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DUTY), "result raised outside duty step")
  `SPB_ASSERT_IMP(a_idx_bound, clk, rst_n, state_r == S_DUTY, spb_pkg::CNT_W'(idx_r) < slot_cnt_r, "module index beyond loaded slots")

endmodule
